// ----- src/gsm7_alphabet_septet_packer_assert.svh -----
// Assertion macros shared by the septet packer checks.
`ifndef GSM7_ALPHABET_SEPTET_PACKER_ASSERT_SVH
`define GSM7_ALPHABET_SEPTET_PACKER_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define GSM7_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gsm7 packer check failed");

// Next-cycle implication, disabled during reset
`define GSM7_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gsm7 packer check failed");

`endif

// ----- src/gsm7_pkg.sv -----
package gsm7_pkg;

   // Payload of one input transfer
   typedef struct packed {
      logic [15:0] char_code;
      logic        last_char;
   } req_type;

   // Payload of one result transfer
   typedef struct packed {
      logic [7:0] octet;
      logic       octet_valid;
      logic       unmappable;
      logic       last_result;
   } rsp_type;

   // Classified character handed from front to back
   typedef struct packed {
      logic [1:0]  septet_count;   // 0, 1 or 2 septets to pack
      logic [13:0] septets;        // second septet in [13:7], first in [6:0]
      logic        last_char;
      logic        unmappable;
   } cmd_type;

   localparam logic [6:0] ESC_SEPTET = 7'h1B;
   localparam logic [7:0] NO_CODE    = 8'hFF;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Latin-1 to GSM default alphabet; bit 7 marks the extension table
   localparam logic [7:0] GSM_TABLE [256] = '{
      8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,
      8'hFF,8'hFF,8'h0A,8'hFF,8'h8A,8'h0D,8'hFF,8'hFF,
      8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,
      8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,
      8'h20,8'h21,8'h22,8'h23,8'h02,8'h25,8'h26,8'h27,
      8'h28,8'h29,8'h2A,8'h2B,8'h2C,8'h2D,8'h2E,8'h2F,
      8'h30,8'h31,8'h32,8'h33,8'h34,8'h35,8'h36,8'h37,
      8'h38,8'h39,8'h3A,8'h3B,8'h3C,8'h3D,8'h3E,8'h3F,
      8'h00,8'h41,8'h42,8'h43,8'h44,8'h45,8'h46,8'h47,
      8'h48,8'h49,8'h4A,8'h4B,8'h4C,8'h4D,8'h4E,8'h4F,
      8'h50,8'h51,8'h52,8'h53,8'h54,8'h55,8'h56,8'h57,
      8'h58,8'h59,8'h5A,8'hBC,8'hAF,8'hBE,8'h94,8'h11,
      8'hFF,8'h61,8'h62,8'h63,8'h64,8'h65,8'h66,8'h67,
      8'h68,8'h69,8'h6A,8'h6B,8'h6C,8'h6D,8'h6E,8'h6F,
      8'h70,8'h71,8'h72,8'h73,8'h74,8'h75,8'h76,8'h77,
      8'h78,8'h79,8'h7A,8'hA8,8'hC0,8'hA9,8'hBD,8'hFF,
      8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,
      8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,
      8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,
      8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,
      8'hFF,8'h40,8'hFF,8'h01,8'h24,8'h03,8'hFF,8'h5F,
      8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,
      8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,
      8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'h60,
      8'hFF,8'hFF,8'hFF,8'hFF,8'h5B,8'h0E,8'h1C,8'h09,
      8'hFF,8'h1F,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,
      8'hFF,8'h5D,8'hFF,8'hFF,8'hFF,8'hFF,8'h5C,8'hFF,
      8'h0B,8'hFF,8'hFF,8'hFF,8'h5E,8'hFF,8'hFF,8'h1E,
      8'h7F,8'hFF,8'hFF,8'hFF,8'h7B,8'h0F,8'h1D,8'hFF,
      8'h04,8'h05,8'hFF,8'hFF,8'h07,8'hFF,8'hFF,8'hFF,
      8'hFF,8'h7D,8'h08,8'hFF,8'hFF,8'hFF,8'h7C,8'hFF,
      8'h0C,8'h06,8'hFF,8'hFF,8'h7E,8'hFF,8'hFF,8'hFF
   };

endpackage

// ----- src/gsm7_front.sv -----
module gsm7_front (
   input  logic             req_valid,
   output logic             req_stall,
   input  gsm7_pkg::req_type req_data,
   input  logic             q_full,
   output logic             push,
   output gsm7_pkg::cmd_type cmd
);
   import gsm7_pkg::*;

   logic       wide_char;
   logic [7:0] code;
   logic       unmappable;

   // Accept whenever the queue has room
   assign req_stall = q_full;
   assign push      = req_valid && !q_full;

   // Table lookup and classification
   assign wide_char  = |req_data.char_code[15:8];
   assign code       = GSM_TABLE[req_data.char_code[7:0]];
   assign unmappable = wide_char || (code == NO_CODE);

   always_comb begin
      cmd.last_char  = req_data.last_char;
      cmd.unmappable = unmappable;
      if (unmappable) begin
         cmd.septet_count = 2'd0;
         cmd.septets      = '0;
      end else if (code[7]) begin
         // extension character: escape first, then the code
         cmd.septet_count = 2'd2;
         cmd.septets      = {code[6:0], ESC_SEPTET};
      end else begin
         cmd.septet_count = 2'd1;
         cmd.septets      = {7'd0, code[6:0]};
      end
   end

endmodule

// ----- src/gsm7_queue.sv -----
module gsm7_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  gsm7_pkg::cmd_type cmd_in,
   output logic              full,
   input  logic              pop,
   output gsm7_pkg::cmd_type cmd_out,
   output logic              empty
);
   import gsm7_pkg::*;

   cmd_type                slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   assign full    = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign cmd_out = slot_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage, no reset needed
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= cmd_in;
      end
   end

endmodule

// ----- src/gsm7_back.sv -----
module gsm7_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              fill_bits,
   input  logic              q_empty,
   input  gsm7_pkg::cmd_type cmd,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output gsm7_pkg::rsp_type rsp_data
);
   import gsm7_pkg::*;

   // Packing state
   logic [7:0]  acc_ff, acc_in;
   logic [2:0]  pend_ff, pend_in;
   logic        start_ff, start_in;

   // Octets of the current character still to be sent
   logic [15:0] job_word_ff, job_word_in;
   logic [1:0]  job_left_ff, job_left_in;
   logic        job_unm_ff, job_unm_in;

   // Output register
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   logic        out_free;
   logic [2:0]  pend_eff;
   logic [13:0] sept_bits;
   logic [23:0] word;
   logic [4:0]  total;
   logic [1:0]  nfull;
   logic [2:0]  rem;
   logic [1:0]  noct;
   logic [1:0]  nres;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign pop       = out_free && (job_left_ff == 2'd0) && !q_empty;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Pack the command's septets on top of the pending bits
   always_comb begin
      pend_eff = pend_ff;
      if (start_ff && fill_bits && (cmd.septet_count != 2'd0)) begin
         pend_eff = 3'd1;
      end
      case (cmd.septet_count)
         2'd1:    sept_bits = {7'd0, cmd.septets[6:0]};
         2'd2:    sept_bits = cmd.septets;
         default: sept_bits = '0;
      endcase
      word  = {16'd0, acc_ff} | ({10'd0, sept_bits} << pend_eff);
      total = {2'd0, pend_eff} + 5'(7 * cmd.septet_count);
      nfull = total[4:3];
      rem   = total[2:0];
      noct  = nfull + 2'((cmd.last_char && (rem != 3'd0)) ? 1 : 0);
      nres  = (noct == 2'd0) ? 2'd1 : noct;
   end

   // Result sequencing and state update
   always_comb begin
      acc_in       = acc_ff;
      pend_in      = pend_ff;
      start_in     = start_ff;
      job_word_in  = job_word_ff;
      job_left_in  = job_left_ff;
      job_unm_in   = job_unm_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_free) begin
         if (job_left_ff != 2'd0) begin
            // further octet of the character in progress
            rsp_valid_in            = 1'b1;
            rsp_data_in.octet       = job_word_ff[7:0];
            rsp_data_in.octet_valid = 1'b1;
            rsp_data_in.unmappable  = job_unm_ff;
            rsp_data_in.last_result = (job_left_ff == 2'd1);
            job_word_in             = {8'd0, job_word_ff[15:8]};
            job_left_in             = job_left_ff - 1'b1;
         end else if (!q_empty) begin
            // first result of a new character
            rsp_valid_in            = 1'b1;
            rsp_data_in.octet       = (noct != 2'd0) ? word[7:0] : 8'd0;
            rsp_data_in.octet_valid = (noct != 2'd0);
            rsp_data_in.unmappable  = cmd.unmappable;
            rsp_data_in.last_result = (nres == 2'd1);
            job_word_in             = word[23:8];
            job_left_in             = nres - 1'b1;
            job_unm_in              = cmd.unmappable;
            if (cmd.last_char) begin
               acc_in   = '0;
               pend_in  = '0;
               start_in = 1'b1;
            end else begin
               acc_in   = word[{nfull, 3'b000} +: 8];
               pend_in  = rem;
               start_in = start_ff && (cmd.septet_count == 2'd0);
            end
         end else begin
            rsp_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         pend_ff      <= '0;
         start_ff     <= 1'b1;
         job_left_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         pend_ff      <= pend_in;
         start_ff     <= start_in;
         job_left_ff  <= job_left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      job_word_ff <= job_word_in;
      job_unm_ff  <= job_unm_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ----- src/gsm7_alphabet_septet_packer.sv -----
// Channel  Handshake             Payload
// req      req_valid/req_stall   gsm7_pkg::req_type  (char_code, last_char)
// rsp      rsp_valid/rsp_stall   gsm7_pkg::rsp_type  (octet, octet_valid, unmappable,
//                                                     last_result)
// csr      csr_valid/csr_ready   csr_data            (fill_bits)
//
// One character is accepted per cycle while the queue has room; the packing unit sends
// one result per cycle while rsp is not stalled, 1 to 3 results per character.
// A 2-entry command queue sits between lookup and packing; req_stall is queue full.
// Results leave from a register, loaded whenever rsp is free or not stalled.
// Reset is synchronous: empty queue, empty accumulator, start of message, fill off.
module gsm7_alphabet_septet_packer (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  gsm7_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output gsm7_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_data
);
   import gsm7_pkg::*;

   logic    fill_bits_ff;
   logic    q_full;
   logic    q_empty;
   logic    push;
   logic    pop;
   cmd_type front_cmd;
   cmd_type queue_cmd;

   // Configuration register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_bits_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         fill_bits_ff <= csr_data;
      end
   end

   gsm7_front u_front (
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_full    (q_full),
      .push      (push),
      .cmd       (front_cmd)
   );

   gsm7_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .cmd_in  (front_cmd),
      .full    (q_full),
      .pop     (pop),
      .cmd_out (queue_cmd),
      .empty   (q_empty)
   );

   gsm7_back u_back (
      .clock     (clock),
      .reset     (reset),
      .fill_bits (fill_bits_ff),
      .q_empty   (q_empty),
      .cmd       (queue_cmd),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- src/gsm7_checker.sv -----
`include "gsm7_alphabet_septet_packer_assert.svh"

module gsm7_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input gsm7_pkg::rsp_type rsp_data
);

   // A stalled result holds
   `GSM7_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
                     rsp_valid && $stable(rsp_data))

   // A result without an octet is empty and closes its character
   `GSM7_ASSERT_NOW(a_empty_result, clock, reset, rsp_valid && !rsp_data.octet_valid,
                    rsp_data.octet == 8'd0 && rsp_data.last_result)

   // A character's results continue with the same mappability flag
   `GSM7_ASSERT_NEXT(a_unm_same, clock, reset,
                     rsp_valid && !rsp_stall && !rsp_data.last_result,
                     !rsp_valid || rsp_data.unmappable == $past(rsp_data.unmappable))

   // Nothing is shown in the first cycle after reset
   `GSM7_ASSERT_NOW(a_reset_quiet, clock, reset, $past(reset), !rsp_valid)

endmodule

bind gsm7_alphabet_septet_packer gsm7_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ----- bench/gsm7_alphabet_septet_packer_test.sv -----
module gsm7_alphabet_septet_packer_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [6:0] ESCAPE_SEPTET = 7'h1B;
   localparam logic [7:0] NO_GSM_CODE   = 8'hFF;
   localparam int         PHASE_ITEMS   = 60;
   localparam int         RANDOM_PHASES = 4;

   // DUT ports
   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   gsm7_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   gsm7_pkg::rsp_type rsp_data;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic              csr_data  = 1'b0;

   // Packer model state
   logic [7:0] pk_acc   = 8'h00;
   logic [2:0] pk_count = 3'd0;
   logic       pk_start = 1'b1;
   logic       fill_mode = 1'b0;
   logic [7:0] new_octets[$];
   gsm7_pkg::rsp_type expected_rsps[$];

   // Traffic shaping and bookkeeping
   bit no_idle    = 1'b0;
   int burst_left = 0;
   int stall_left = 0;
   int chars_sent = 0;
   int msgs_sent  = 0;
   int rsps_checked = 0;
   int fill_writes  = 0;
   bit failed = 1'b0;

   gsm7_alphabet_septet_packer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #6 clock = ~clock;

   // Latin-1 to GSM default alphabet; bit 7 set means extension table
   function automatic logic [7:0] gsm_code_of(input logic [7:0] c);
      case (c)
         8'h0A: return 8'h0A;
         8'h0C: return 8'h8A;
         8'h0D: return 8'h0D;
         8'h24: return 8'h02;
         8'h40: return 8'h00;
         8'h5B: return 8'hBC;
         8'h5C: return 8'hAF;
         8'h5D: return 8'hBE;
         8'h5E: return 8'h94;
         8'h5F: return 8'h11;
         8'h7B: return 8'hA8;
         8'h7C: return 8'hC0;
         8'h7D: return 8'hA9;
         8'h7E: return 8'hBD;
         8'hA1: return 8'h40;
         8'hA3: return 8'h01;
         8'hA4: return 8'h24;
         8'hA5: return 8'h03;
         8'hA7: return 8'h5F;
         8'hBF: return 8'h60;
         8'hC4: return 8'h5B;
         8'hC5: return 8'h0E;
         8'hC6: return 8'h1C;
         8'hC7: return 8'h09;
         8'hC9: return 8'h1F;
         8'hD1: return 8'h5D;
         8'hD6: return 8'h5C;
         8'hD8: return 8'h0B;
         8'hDC: return 8'h5E;
         8'hDF: return 8'h1E;
         8'hE0: return 8'h7F;
         8'hE4: return 8'h7B;
         8'hE5: return 8'h0F;
         8'hE6: return 8'h1D;
         8'hE8: return 8'h04;
         8'hE9: return 8'h05;
         8'hEC: return 8'h07;
         8'hF1: return 8'h7D;
         8'hF2: return 8'h08;
         8'hF6: return 8'h7C;
         8'hF8: return 8'h0C;
         8'hF9: return 8'h06;
         8'hFC: return 8'h7E;
         default: begin
            // printable ASCII maps to itself, except backquote and DEL
            if ((c >= 8'h20 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) begin
               return c;
            end
            return NO_GSM_CODE;
         end
      endcase
   endfunction

   // Append one septet LSB-first; full octets go to new_octets
   function automatic void pack_septet(input logic [6:0] septet);
      logic [15:0] bits;
      logic [3:0]  total;
      if (pk_start) begin
         // fill bit goes in with the first packed septet of a message
         if (fill_mode) begin
            pk_acc   = 8'h00;
            pk_count = 3'd1;
         end
         pk_start = 1'b0;
      end
      bits  = {8'h00, pk_acc} | ({9'h000, septet} << pk_count);
      total = {1'b0, pk_count} + 4'd7;
      if (total >= 4'd8) begin
         new_octets.push_back(bits[7:0]);
         pk_acc   = bits[15:8];
         pk_count = 3'(total - 4'd8);
      end else begin
         pk_acc   = bits[7:0];
         pk_count = total[2:0];
      end
   endfunction

   // Work out the results of one accepted character
   function automatic void predict_char(input logic [15:0] code, input logic last);
      logic [7:0]        gsm;
      logic              unmap;
      gsm7_pkg::rsp_type r;
      new_octets.delete();
      gsm   = gsm_code_of(code[7:0]);
      unmap = (code[15:8] != 8'h00) || (gsm == NO_GSM_CODE);
      if (!unmap) begin
         if (gsm[7]) begin
            pack_septet(ESCAPE_SEPTET);
         end
         pack_septet(gsm[6:0]);
      end
      if (last) begin
         // flush partial octet, zero padded, then back to message start
         if (pk_count != 3'd0) begin
            new_octets.push_back(pk_acc);
         end
         pk_acc   = 8'h00;
         pk_count = 3'd0;
         pk_start = 1'b1;
      end
      if (new_octets.size() == 0) begin
         r = '{octet: 8'h00, octet_valid: 1'b0, unmappable: unmap, last_result: 1'b1};
         expected_rsps.push_back(r);
      end else begin
         foreach (new_octets[k]) begin
            r.octet       = new_octets[k];
            r.octet_valid = 1'b1;
            r.unmappable  = unmap;
            r.last_result = (k == new_octets.size() - 1);
            expected_rsps.push_back(r);
         end
      end
   endfunction

   // One character transfer; the sender may idle between bursts
   task automatic send_char(input logic [15:0] code, input logic last);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = (no_idle || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
         if (gap != 0) begin
            @(negedge clock);
            req_valid = 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_valid = 1'b1;
      req_data  = '{char_code: code, last_char: last};
      do @(posedge clock); while (req_stall);
      predict_char(code, last);
      chars_sent++;
      if (last) begin
         msgs_sent++;
      end
   endtask

   // Stop sending and wait for every outstanding result
   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Register write, only with the packer idle
   task automatic write_fill(input logic value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_data  = value;
      do @(posedge clock); while (!csr_ready);
      fill_mode = value;
      fill_writes++;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Receiver stalls in short runs, with occasional long free stretches
   always @(negedge clock) begin
      if (no_idle) begin
         rsp_stall = 1'b0;
      end else if (stall_left != 0) begin
         stall_left--;
      end else if (rsp_stall) begin
         rsp_stall  = 1'b0;
         stall_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(0, 5);
      end else begin
         rsp_stall  = 1'b1;
         stall_left = $urandom_range(0, 3);
      end
   end

   // Compare each result transfer with the oldest expectation
   always @(posedge clock) begin : check_rsp
      gsm7_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            $error("unexpected result: octet %h valid %b", rsp_data.octet,
                   rsp_data.octet_valid);
            failed = 1'b1;
         end else begin
            want = expected_rsps.pop_front();
            rsps_checked++;
            if (rsp_data.octet !== want.octet) begin
               $error("octet: expected %h, got %h", want.octet, rsp_data.octet);
               failed = 1'b1;
            end
            if (rsp_data.octet_valid !== want.octet_valid) begin
               $error("octet_valid: expected %b, got %b", want.octet_valid,
                      rsp_data.octet_valid);
               failed = 1'b1;
            end
            if (rsp_data.unmappable !== want.unmappable) begin
               $error("unmappable: expected %b, got %b", want.unmappable,
                      rsp_data.unmappable);
               failed = 1'b1;
            end
            if (rsp_data.last_result !== want.last_result) begin
               $error("last_result: expected %b, got %b", want.last_result,
                      rsp_data.last_result);
               failed = 1'b1;
            end
         end
      end
   end

   // Random character: mostly mappable text, some escapes, some unmappable
   function automatic logic [15:0] random_char();
      int         pick;
      logic [7:0] c;
      logic [7:0] ext_chars[9] = '{8'h0C, 8'h5B, 8'h5C, 8'h5D, 8'h5E,
                                   8'h7B, 8'h7C, 8'h7D, 8'h7E};
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         do c = 8'($urandom_range(0, 255)); while (gsm_code_of(c) == NO_GSM_CODE);
         return {8'h00, c};
      end else if (pick < 72) begin
         return {8'h00, ext_chars[$urandom_range(0, 8)]};
      end else if (pick < 84) begin
         do c = 8'($urandom_range(0, 255)); while (gsm_code_of(c) != NO_GSM_CODE);
         return {8'h00, c};
      end
      return 16'($urandom_range(16'h0100, 16'hFFFF));
   endfunction

   // Plain mapping, commercial at, wide and unmappable characters
   task automatic test_basic_mapping();
      write_fill(1'b0);
      send_char(16'h0040, 1'b1);
      send_char(16'h0000, 1'b0);
      send_char(16'h00FF, 1'b0);
      send_char(16'h0100, 1'b0);
      send_char(16'hFFFF, 1'b1);
      send_char(16'h0068, 1'b0);
      send_char(16'h0065, 1'b0);
      send_char(16'h006C, 1'b0);
      send_char(16'h006C, 1'b0);
      send_char(16'h006F, 1'b1);
      drain();
   endtask

   // Extension characters at different bit offsets
   task automatic test_escapes();
      send_char(16'h007B, 1'b0);
      send_char(16'h0041, 1'b0);
      send_char(16'h000C, 1'b0);
      send_char(16'h005D, 1'b0);
      send_char(16'h0020, 1'b0);
      send_char(16'h007E, 1'b1);
      drain();
   endtask

   // Fill bit: lands with the first packed septet, not the first character
   task automatic test_fill_bit();
      write_fill(1'b1);
      send_char(16'h8000, 1'b0);
      send_char(16'h0041, 1'b0);
      send_char(16'h00E9, 1'b1);
      send_char(16'h0024, 1'b1);
      send_char(16'h0060, 1'b1);
      drain();
      write_fill(1'b0);
      drain();
   endtask

   // Random messages over several fill settings and idle patterns
   task automatic test_random_messages();
      int count;
      int len;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         write_fill((phase == 3) ? 1'($urandom_range(0, 1)) : phase[0]);
         no_idle = (phase == 2);
         count = 0;
         while (count < PHASE_ITEMS) begin
            if ($urandom_range(0, 9) == 0) begin
               // noise: any code, last flag at random
               send_char(16'($urandom_range(0, 16'hFFFF)), 1'($urandom_range(0, 1)));
               count++;
            end else begin
               len = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 20)
                                                 : $urandom_range(1, 9);
               for (int i = 0; i < len; i++) begin
                  send_char(random_char(), i == len - 1);
               end
               count += len;
            end
         end
         drain();
      end
      no_idle = 1'b0;
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_basic_mapping();
      test_escapes();
      test_fill_bit();
      test_random_messages();
      drain();
      repeat (20) @(posedge clock);
      if (expected_rsps.size() != 0) begin
         $error("%0d expected results never arrived", expected_rsps.size());
         failed = 1'b1;
      end
      $display("Sent %0d characters in %0d messages, checked %0d results,",
               chars_sent, msgs_sent, rsps_checked);
      $display("with %0d fill bit writes covering fill off and on.", fill_writes);
      if (!failed) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2000000;
      $display("Some tests failed");
      $finish;
   end

endmodule
